FILE: src/aes_pkg.sv
// Shared AES types, constants and byte-level functions.
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int RkWords = 4 * (NumRounds + 1);

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0 = 3'd1;
  localparam logic [2:0] REG_KEY_W1 = 3'd2;
  localparam logic [2:0] REG_KEY_W2 = 3'd3;
  localparam logic [2:0] REG_KEY_W3 = 3'd4;

  localparam logic OP_ENCRYPT = 1'b0;

  typedef logic [127:0] block_t;
  typedef logic [RkWords*32-1:0] rk_bus_t;

  typedef struct packed {
    logic   vld;
    logic   dec;
    logic   last;
    block_t blk;
  } cell_t;

  localparam logic [2047:0] SBOX_TAB = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic logic [7:0] sbox(input logic [7:0] a);
    sbox = SBOX_TAB[2047 - 8*a -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    inv_sbox = r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k] = c[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      if (inv) begin
        m0[k] = x8[k] ^ x4[k] ^ x2[k];
        m1[k] = x8[k] ^ x2[k] ^ a[k];
        m2[k] = x8[k] ^ x4[k] ^ a[k];
        m3[k] = x8[k] ^ a[k];
      end else begin
        m0[k] = x2[k];
        m1[k] = x2[k] ^ a[k];
        m2[k] = a[k];
        m3[k] = a[k];
      end
    end
    for (int rr = 0; rr < 4; rr++) begin
      r[31-8*rr -: 8] = m0[rr] ^ m1[(rr+1)&3] ^ m2[(rr+2)&3] ^ m3[(rr+3)&3];
    end
    mix_col = r;
  endfunction

endpackage

FILE: src/aes_key_cell.sv
// One key expansion cell: derives the next round key word from the previous words.
module aes_key_cell (
  input  logic         clk,
  input  logic [255:0] win,
  input  logic [1:0]   ksz,
  input  logic [3:0]   step,
  input  logic [7:0]   rcon,
  output logic [255:0] wout,
  output logic [1:0]   ksz_out
);
  import aes_pkg::*;

  logic [255:0] wnxt;
  logic [31:0]  t;
  logic [31:0]  nw;
  logic [2:0]   nk;

  always_comb begin
    nk = (ksz == KEY_128) ? 3'd4 : (ksz == KEY_192) ? 3'd6 : 3'd0;
    wnxt = win;
    t = (nk == 3'd4) ? win[159:128] : (nk == 3'd6) ? win[95:64] : win[31:0];
    if (step == 4'd0) begin
      t = {sbox(t[23:16]) ^ rcon, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
    end else if (nk == 3'd0 && step == 4'd4) begin
      t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    end
    nw = win[255:224] ^ t;
    // Window shifts one word; the new word enters behind the active key length.
    wnxt = {win[223:0], 32'h0};
    case (nk)
      3'd4:    wnxt[159:128] = nw;
      3'd6:    wnxt[95:64] = nw;
      default: wnxt[31:0] = nw;
    endcase
  end

  always_ff @(posedge clk) begin
    wout    <= wnxt;
    ksz_out <= ksz;
  end
endmodule

FILE: src/aes_round_cell.sv
// One cipher round cell with its output register.
module aes_round_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  last_en,
  input  aes_pkg::cell_t        cin,
  input  aes_pkg::block_t       ekey,
  input  aes_pkg::block_t       dkey,
  output aes_pkg::cell_t        cout
);
  import aes_pkg::*;

  cell_t  cnxt;
  block_t sb;
  block_t sr;
  block_t mc;
  block_t ak;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cin.dec) begin
          sr[127-8*(r+4*((c+r)&3)) -: 8] = cin.blk[127-8*(r+4*c) -: 8];
        end else begin
          sr[127-8*(r+4*c) -: 8] = cin.blk[127-8*(r+4*((c+r)&3)) -: 8];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = cin.dec ? inv_sbox(sr[127-8*i -: 8]) : sbox(sr[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      mc[127-32*c -: 32] = mix_col(sb[127-32*c -: 32], cin.dec);
    end
    // Decryption uses the equivalent inverse cipher: the key is pre-mixed.
    ak = (last_en ? sb : mc) ^ (cin.dec ? dkey : ekey);
    cnxt = cin;
    if (!cin.last) begin
      cnxt.blk  = ak;
      cnxt.last = last_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout.vld <= 1'b0;
    end else begin
      cout.vld <= cnxt.vld;
    end
    cout.dec  <= cnxt.dec;
    cout.last <= cnxt.last;
    cout.blk  <= cnxt.blk;
  end
endmodule

FILE: src/aes_block_cipher.sv
// Top level: configuration registers, key schedule and the pipelined AES rounds.
//
// Channel | Direction | Ports
// in      | request   | start, busy, in_operation, in_data_high, in_data_low
// out     | result    | out_valid, out_result_high, out_result_low
// cfg     | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A new request is taken every cycle while busy is low.
// Busy is high after reset and after every register write while the round keys
// settle through the key expansion chain.
// The pipeline has one input register and fourteen round cells.
// Short keys finish early and pass unchanged through the remaining cells.
// Reset is synchronous and clears the valid flags and the key configuration registers.
module aes_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import aes_pkg::*;

  localparam logic [5:0] SettleCycles = 6'd60;

  logic [1:0]  cfg_key_size_r;
  logic [63:0] cfg_key_r [4];
  logic        wr;
  logic [2:0]  ridx;
  logic [5:0]  settle_r;

  assign pready = 1'b1;
  assign busy   = (settle_r != 6'd0);
  assign wr     = psel & penable & pwrite;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SettleCycles;
    end else if (wr) begin
      settle_r <= SettleCycles;
    end else if (settle_r != 6'd0) begin
      settle_r <= settle_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_key_size_r <= 2'd0;
      for (int i = 0; i < 4; i++) cfg_key_r[i] <= 64'h0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (ridx)
        REG_KEY_SIZE: cfg_key_size_r <= pwdata[1:0];
        REG_KEY_W0:   cfg_key_r[0] <= pwdata;
        REG_KEY_W1:   cfg_key_r[1] <= pwdata;
        REG_KEY_W2:   cfg_key_r[2] <= pwdata;
        REG_KEY_W3:   cfg_key_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_KEY_SIZE: prdata = {62'h0, cfg_key_size_r};
      REG_KEY_W0:   prdata = cfg_key_r[0];
      REG_KEY_W1:   prdata = cfg_key_r[1];
      REG_KEY_W2:   prdata = cfg_key_r[2];
      REG_KEY_W3:   prdata = cfg_key_r[3];
      default:      prdata = 64'h0;
    endcase
  end

  function automatic logic [7:0] rcon_of(input int n);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 1; i < 11; i++) begin
      if (i < n) r = xt(r);
    end
    rcon_of = r;
  endfunction

  // Key expansion chain: every cell adds one word; it runs freely off the registers.
  localparam int NumKc = RkWords;
  logic [255:0] kw   [NumKc+1];
  logic [1:0]   kks  [NumKc+1];
  logic [2:0]   nkc;
  assign kw[0]  = {cfg_key_r[0], cfg_key_r[1], cfg_key_r[2], cfg_key_r[3]};
  assign kks[0] = cfg_key_size_r;
  assign nkc = (cfg_key_size_r == KEY_128) ? 3'd4 : (cfg_key_size_r == KEY_192) ? 3'd6 : 3'd0;

  // Word i of the schedule is taken from the front of the window after i steps.
  logic [31:0] rkw [RkWords];

  genvar g;
  generate
    for (g = 0; g < NumKc; g++) begin : g_kc
      localparam int WI4 = g + 4;
      localparam int WI6 = g + 6;
      localparam int WI8 = g + 8;
      logic [3:0] st;
      logic [7:0] rc;
      logic [7:0] rc4;
      logic [7:0] rc6;
      logic [7:0] rc8;
      assign rc4 = rcon_of(WI4 / 4);
      assign rc6 = rcon_of(WI6 / 6);
      assign rc8 = rcon_of(WI8 / 8);
      always_comb begin
        case (kks[g])
          KEY_128: begin st = 4'(WI4 % 4); rc = rc4; end
          KEY_192: begin st = 4'(WI6 % 6); rc = rc6; end
          default: begin st = 4'(WI8 % 8); rc = rc8; end
        endcase
      end
      aes_key_cell u_kc (
        .clk(clk), .win(kw[g]), .ksz(kks[g]), .step(st), .rcon(rc),
        .wout(kw[g+1]), .ksz_out(kks[g+1]));
      assign rkw[g] = kw[g][255:224];
    end
  endgenerate

  // Round keys are registered so the datapath sees a stable set.
  block_t rk_r [NumRounds+1];
  block_t dk_r [NumRounds+1];
  logic [3:0] nr;
  assign nr = (cfg_key_size_r == KEY_128) ? 4'd10 : (cfg_key_size_r == KEY_192) ? 4'd12 : 4'd14;

  always_ff @(posedge clk) begin
    for (int r = 0; r <= NumRounds; r++) begin
      rk_r[r] <= {rkw[4*r], rkw[4*r+1], rkw[4*r+2], rkw[4*r+3]};
      for (int c = 0; c < 4; c++) begin
        dk_r[r][127-32*c -: 32] <= mix_col(rkw[4*r+c], 1'b1);
      end
    end
  end

  // Decryption round j uses key nr-j; the initial step uses nr.
  block_t ek [NumRounds+1];
  block_t dk [NumRounds+1];
  always_comb begin
    for (int j = 0; j <= NumRounds; j++) begin
      ek[j] = rk_r[j];
      dk[j] = dk_r[0];
      for (int r = 0; r <= NumRounds; r++) begin
        if (4'(r) == nr - 4'(j)) dk[j] = (j == 0 || 4'(r) == 4'd0) ? rk_r[r] : dk_r[r];
      end
    end
    if (nkc == 3'd7) ek[0] = rk_r[0];
  end

  cell_t pipe [NumRounds+1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe[0].vld <= 1'b0;
    end else begin
      pipe[0].vld <= start & ~busy;
    end
    pipe[0].dec  <= (in_operation != OP_ENCRYPT);
    pipe[0].last <= 1'b0;
    pipe[0].blk  <= {in_data_high, in_data_low} ^
      ((in_operation != OP_ENCRYPT) ? dk[0] : ek[0]);
  end

  generate
    for (g = 1; g <= NumRounds; g++) begin : g_rc
      aes_round_cell u_rc (
        .clk(clk), .rst_n(rst_n), .last_en(4'(g) == nr),
        .cin(pipe[g-1]), .ekey(ek[g]), .dkey(dk[g]), .cout(pipe[g]));
    end
  endgenerate

  assign out_valid       = pipe[NumRounds].vld;
  assign out_result_high = pipe[NumRounds].blk[127:64];
  assign out_result_low  = pipe[NumRounds].blk[63:0];

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> busy) else $error("busy low after a register write");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(pipe[NumRounds-1].vld)) else $error("stray result");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule
